// ===== rtl/core/pba_pkg.sv =====
package pba_pkg;

  // Identifier and map geometry
  localparam int ID_W        = 10;
  localparam int MAP_ENTRIES = 1024;
  localparam int WORD_W      = 32;
  localparam int BIT_W       = $clog2(WORD_W);
  localparam int MAP_WORDS   = (MAP_ENTRIES + WORD_W - 1) / WORD_W;
  localparam int WADDR_W     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int SZ_W        = ($clog2(MAP_ENTRIES + 1) > ID_W + 1) ?
                               $clog2(MAP_ENTRIES + 1) : ID_W + 1;

  // Register port
  localparam int PADDR_W = 3;
  localparam int DATA_W  = 32;
  localparam int RIDX_W  = PADDR_W - 2;

  localparam logic [RIDX_W-1:0] REG_ID_LOW  = 1'b0;
  localparam logic [RIDX_W-1:0] REG_ID_HIGH = 1'b1;

  localparam logic [ID_W-1:0] ID_LOW_RST  = 10'd100;
  localparam logic [ID_W-1:0] ID_HIGH_RST = 10'd1000;

  // Request codes
  localparam logic MODE_ALLOC   = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef struct packed {
    logic [ID_W-1:0] id_low;
    logic [ID_W-1:0] id_high;
  } cfg_t;

  typedef struct packed {
    logic               we;
    logic [WADDR_W-1:0] addr;
    logic [WORD_W-1:0]  data;
  } ram_wr_t;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_REL   = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

endpackage

// ===== rtl/core/pid_bitmap_allocator.sv =====
// First-fit identifier allocator. Identifiers id_low..id_high (capped at
// MAP_ENTRIES of them) are tracked by one in-use bit each, packed 32 to a word
// in a single-port-read, single-port-write RAM. An allocate request scans the
// map word by word from the bottom, one word per cycle, marks the lowest free
// bit and returns id_low plus its index; if the range holds no free entry the
// result is status 1 with identifier zero. A release request checks the
// identifier against the range (status 2 if outside), otherwise clears its bit
// with a read-modify-write. Steps: an allocate moves from idle to the scan
// state, which reads one word per visit (up to 32 words for the full map),
// then to the done state; an in-range release moves through the
// read-modify-write state to the done state; an out-of-range release or an
// allocate on an empty range goes straight from idle to the done state.
// One item is in flight at a time; a finished result sits in an output
// register, and the next item is taken as soon as that result is handed off
// to it. After reset the block clears the map word by word over all MAP_WORDS
// words (32 at the default size) before raising in_ready; register writes are
// taken during that pass. Registers: id_low at byte 0, id_high at byte 4,
// reset 100 and 1000; write them only while the block is idle.
module pid_bitmap_allocator (
  input  logic                          clk,
  input  logic                          rst_n,
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pba_pkg::PADDR_W-1:0]   paddr,
  input  logic [pba_pkg::DATA_W-1:0]    pwdata,
  output logic [pba_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  // request channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_mode,
  input  logic [pba_pkg::ID_W-1:0]      in_release_id,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pba_pkg::ID_W-1:0]      out_granted_id,
  output pba_pkg::status_t              out_status
);
  import pba_pkg::*;

  cfg_t               cfg;
  ram_wr_t            ram_wr;
  logic [WADDR_W-1:0] ram_raddr;
  logic [WORD_W-1:0]  ram_rdata;

  // Configuration registers; reads return the stored value
  pba_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Sequencer: clear pass, word scan, release read-modify-write, result hold
  pba_engine u_engine (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_release_id  (in_release_id),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_granted_id (out_granted_id),
    .out_status     (out_status),
    .ram_raddr      (ram_raddr),
    .ram_rdata      (ram_rdata),
    .ram_wr         (ram_wr)
  );

  // In-use map, one bit per identifier index
  pba_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_wr.we),
    .waddr (ram_wr.addr),
    .wdata (ram_wr.data),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

// ===== rtl/core/pba_ram.sv =====
module pba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/pba_cfg.sv =====
module pba_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pba_pkg::PADDR_W-1:0]   paddr,
  input  logic [pba_pkg::DATA_W-1:0]    pwdata,
  output logic [pba_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  output pba_pkg::cfg_t                 cfg
);
  import pba_pkg::*;

  cfg_t              cfg_r, cfg_nxt;
  logic [RIDX_W-1:0] ridx;
  logic              wr_en;

  assign ridx   = paddr[PADDR_W-1:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (ridx)
        REG_ID_LOW:  cfg_nxt.id_low  = pwdata[ID_W-1:0];
        REG_ID_HIGH: cfg_nxt.id_high = pwdata[ID_W-1:0];
        default:     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_ID_LOW:  prdata = DATA_W'(cfg_r.id_low);
      REG_ID_HIGH: prdata = DATA_W'(cfg_r.id_high);
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.id_low  <= ID_LOW_RST;
      cfg_r.id_high <= ID_HIGH_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== rtl/core/pba_engine.sv =====
module pba_engine (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pba_pkg::cfg_t                 cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_mode,
  input  logic [pba_pkg::ID_W-1:0]      in_release_id,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pba_pkg::ID_W-1:0]      out_granted_id,
  output pba_pkg::status_t              out_status,
  output logic [pba_pkg::WADDR_W-1:0]   ram_raddr,
  input  logic [pba_pkg::WORD_W-1:0]    ram_rdata,
  output pba_pkg::ram_wr_t              ram_wr
);
  import pba_pkg::*;

  state_t             state_r, state_nxt;
  logic [WADDR_W-1:0] word_r, word_nxt;
  logic [SZ_W-1:0]    rel_r, rel_nxt;
  logic [ID_W-1:0]    res_id_r, res_id_nxt;
  status_t            res_st_r, res_st_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [ID_W-1:0]    out_id_r, out_id_nxt;
  status_t            out_st_r, out_st_nxt;

  logic [SZ_W-1:0]    span, n_c, rel_c, base, rem;
  logic               rel_bad, last;
  logic [WORD_W-1:0]  mask, free, lowest;
  logic [BIT_W-1:0]   fb;
  logic [WADDR_W-1:0] rel_word;

  // Usable range size, capped at the map size; zero when id_high is below id_low
  always_comb begin
    span = SZ_W'(cfg.id_high) - SZ_W'(cfg.id_low) + SZ_W'(1);
    if (cfg.id_high < cfg.id_low) begin
      n_c = '0;
    end else if (span > SZ_W'(MAP_ENTRIES)) begin
      n_c = SZ_W'(MAP_ENTRIES);
    end else begin
      n_c = span;
    end
  end

  assign rel_c    = SZ_W'(in_release_id) - SZ_W'(cfg.id_low);
  assign rel_bad  = (in_release_id < cfg.id_low) || (rel_c >= n_c);
  assign rel_word = WADDR_W'(rel_c >> BIT_W);

  // Word under evaluation: mask off entries past the range, pick lowest free bit
  always_comb begin
    base   = SZ_W'(word_r) << BIT_W;
    rem    = n_c - base;
    last   = rem <= SZ_W'(WORD_W);
    if (rem >= SZ_W'(WORD_W)) begin
      mask = '1;
    end else begin
      mask = (WORD_W'(1) << rem[BIT_W-1:0]) - WORD_W'(1);
    end
    free   = ~ram_rdata & mask;
    lowest = free & (~free + WORD_W'(1));
    fb     = '0;
    for (int b = 0; b < WORD_W; b++) begin
      fb = fb | (lowest[b] ? BIT_W'(b) : '0);
    end
  end

  always_comb begin
    ram_raddr = word_r + WADDR_W'(1);
    if (state_r == S_IDLE) begin
      ram_raddr = (in_mode == MODE_RELEASE) ? rel_word : '0;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    word_nxt      = word_r;
    rel_nxt       = rel_r;
    res_id_nxt    = res_id_r;
    res_st_nxt    = res_st_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_id_nxt    = out_id_r;
    out_st_nxt    = out_st_r;
    ram_wr        = '0;

    case (state_r)
      S_CLEAR: begin
        ram_wr.we   = 1'b1;
        ram_wr.addr = word_r;
        ram_wr.data = '0;
        word_nxt    = word_r + WADDR_W'(1);
        if (word_r == WADDR_W'(MAP_WORDS - 1)) begin
          word_nxt  = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          res_id_nxt = '0;
          word_nxt   = '0;
          rel_nxt    = rel_c;
          if (in_mode == MODE_ALLOC) begin
            if (n_c == '0) begin
              res_st_nxt = ST_FULL;
              state_nxt  = S_DONE;
            end else begin
              state_nxt  = S_SCAN;
            end
          end else begin
            if (rel_bad) begin
              res_st_nxt = ST_RANGE;
              state_nxt  = S_DONE;
            end else begin
              state_nxt  = S_REL;
            end
          end
        end
      end
      S_SCAN: begin
        if (free != '0) begin
          ram_wr.we   = 1'b1;
          ram_wr.addr = word_r;
          ram_wr.data = ram_rdata | lowest;
          res_id_nxt  = ID_W'(SZ_W'(cfg.id_low) + base + SZ_W'(fb));
          res_st_nxt  = ST_OK;
          state_nxt   = S_DONE;
        end else if (last) begin
          res_st_nxt  = ST_FULL;
          state_nxt   = S_DONE;
        end else begin
          word_nxt    = word_r + WADDR_W'(1);
        end
      end
      S_REL: begin
        ram_wr.we   = 1'b1;
        ram_wr.addr = WADDR_W'(rel_r >> BIT_W);
        ram_wr.data = ram_rdata & ~(WORD_W'(1) << rel_r[BIT_W-1:0]);
        res_st_nxt  = ST_OK;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_id_nxt    = res_id_r;
          out_st_nxt    = res_st_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_ready       = (state_r == S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_granted_id = out_id_r;
  assign out_status     = out_st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      word_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      word_r      <= word_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rel_r    <= rel_nxt;
    res_id_r <= res_id_nxt;
    res_st_r <= res_st_nxt;
    out_id_r <= out_id_nxt;
    out_st_r <= out_st_nxt;
  end

endmodule

// ===== rtl/core/pba_checker.sv =====
module pba_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [pba_pkg::ID_W-1:0]      out_granted_id,
  input pba_pkg::status_t              out_status,
  input logic                          pready
);
  import pba_pkg::*;

  // A held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_granted_id) && $stable(out_status))
    else $error("result changed while stalled");

  // Any failed request returns identifier zero
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL || out_status == ST_RANGE) |-> out_granted_id == '0)
    else $error("nonzero identifier on failed request");

  // One request at a time: the engine goes busy right after taking an item
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item accepted while busy");

  // The request channel is closed right after reset, as the post-reset clear pass begins
  a_clear_pass: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("item accepted during map clear");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    pready)
    else $error("register port stalled");

endmodule

bind pid_bitmap_allocator pba_checker u_pba_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_granted_id (out_granted_id),
  .out_status     (out_status),
  .pready         (pready)
);
